>>> rtl/zoc_pkg.sv
// Package for the zoned output channel with on-time timer.
// Holds the result kind codes, protocol constants and field widths; no dependencies.
`default_nettype none

package zoc_pkg;

   typedef enum logic [1:0] {
      KIND_STATUS   = 2'd0,
      KIND_TURN_OFF = 2'd1,
      KIND_INFO_ON  = 2'd2,
      KIND_INFO_OFF = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      FUNC_EVENT = 1'b0,
      FUNC_TICK  = 1'b1
   } func_type;

   typedef enum logic [7:0] {
      IDX_ENABLE         = 8'd0,
      IDX_INVERT         = 8'd1,
      IDX_ZONE           = 8'd2,
      IDX_SUBZONE        = 8'd3,
      IDX_LIMIT_HOURS    = 8'd4,
      IDX_LIMIT_MINUTES  = 8'd5,
      IDX_CHANNEL_NUMBER = 8'd6
   } reg_index_type;

   localparam logic [15:0] MINUTE_MS      = 16'd60000;
   localparam logic [15:0] CONTROL_CLASS  = 16'd30;
   localparam logic [7:0]  TURN_ON_TYPE   = 8'd5;
   localparam logic [7:0]  TURN_OFF_TYPE  = 8'd6;
   localparam logic [3:0]  CONTROL_SIZE   = 4'd3;
   localparam logic [7:0]  SUBZONE_ALL    = 8'd255;
   localparam logic [5:0]  MINUTES_PER_HR = 6'd60;

endpackage

`default_nettype wire

>>> rtl/zoc_intf.sv
// Channel interfaces of the zoned output channel: request, response and register write.
// Depends on zoc_pkg for the kind and function codes.
`default_nettype none

interface zoc_req_if
   import zoc_pkg::*;
   ();
   logic        valid;
   logic        ready;
   func_type    func;
   logic [15:0] now_ms;
   logic [15:0] event_class;
   logic [7:0]  event_type;
   logic [3:0]  event_size;
   logic [7:0]  event_zone;
   logic [7:0]  event_subzone;

   modport source (output valid, func, now_ms, event_class, event_type, event_size,
                   event_zone, event_subzone, input ready);
   modport sink   (input valid, func, now_ms, event_class, event_type, event_size,
                   event_zone, event_subzone, output ready);
endinterface

interface zoc_rsp_if
   import zoc_pkg::*;
   ();
   logic       valid;
   logic       ready;
   kind_type   kind;
   logic [7:0] channel;
   logic [7:0] out_zone;
   logic [7:0] out_subzone;
   logic       pin_level;
   logic       on_state;
   logic [7:0] elapsed_hours;
   logic [5:0] elapsed_minutes;
   logic       last;

   modport source (output valid, kind, channel, out_zone, out_subzone, pin_level, on_state,
                   elapsed_hours, elapsed_minutes, last, input ready);
   modport sink   (input valid, kind, channel, out_zone, out_subzone, pin_level, on_state,
                   elapsed_hours, elapsed_minutes, last, output ready);
endinterface

interface zoc_csr_if
   import zoc_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/zoned_output_channel_with_timer_top.sv
// Zoned on/off output channel with on-time counters and auto-off request.
// A tick transaction's first result is registered and offered in the cycle after acceptance.
// One transaction per cycle unless results are pending: a tick holds the request side
// until its last result is taken. An event transaction gives no result.
// Reset (synchronous, active high) clears all registers, state and pending results.
// Depends on zoc_pkg and the interfaces in zoc_intf.sv.
`default_nettype none

module zoned_output_channel_with_timer_top
   import zoc_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   zoc_req_if.sink     req_chan,
   zoc_rsp_if.source   rsp_chan,
   zoc_csr_if.sink     csr_chan
);

   typedef struct packed {
      logic [7:0] channel;
      logic [7:0] zone;
      logic [7:0] subzone;
      logic       pin;
      logic       on;
      logic [7:0] hours;
      logic [5:0] minutes;
      logic       pend_off;
      logic       pend_info;
   } rec_type;

   logic        enable_ff, invert_ff;
   logic [7:0]  zone_ff, subzone_ff, lim_h_ff, lim_m_ff, chan_ff;

   logic        on_ff, on_in;
   logic        rep_ff, rep_in;
   logic [15:0] start_ff, start_in;
   logic [5:0]  min_ff, min_in;
   logic [7:0]  hr_ff, hr_in;
   logic        pin_ff, pin_in;

   logic        out_valid_ff, out_valid_in;
   rec_type     rec_ff, rec_in;

   logic        req_take, rsp_take, out_last, ev_match, minute_up;
   logic [15:0] elapsed;
   logic [5:0]  min_inc;

   assign out_last = !rec_ff.pend_off && !rec_ff.pend_info;
   assign req_chan.ready = !out_valid_ff || (rsp_chan.ready && out_last);
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_take = out_valid_ff && rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign ev_match = enable_ff && req_chan.event_class == CONTROL_CLASS
                     && req_chan.event_size == CONTROL_SIZE
                     && req_chan.event_zone == zone_ff
                     && (req_chan.event_subzone == subzone_ff
                         || req_chan.event_subzone == SUBZONE_ALL);

   assign elapsed   = req_chan.now_ms - start_ff;
   assign minute_up = elapsed > MINUTE_MS;
   assign min_inc   = min_ff + 6'd1;

   always_comb begin
      on_in        = on_ff;
      rep_in       = rep_ff;
      start_in     = start_ff;
      min_in       = min_ff;
      hr_in        = hr_ff;
      pin_in       = pin_ff;
      out_valid_in = out_valid_ff;
      rec_in       = rec_ff;

      if (rsp_take) begin
         if (rec_ff.pend_off) begin
            rec_in.pend_off = 1'b0;
         end else if (rec_ff.pend_info) begin
            rec_in.pend_info = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end

      if (req_take) begin
         if (req_chan.func == FUNC_EVENT) begin
            if (ev_match) begin
               if (req_chan.event_type == TURN_OFF_TYPE) begin
                  if (on_in) begin
                     on_in = 1'b0;
                  end else begin
                     rep_in = 1'b1;
                  end
               end
               if (req_chan.event_type == TURN_ON_TYPE) begin
                  if (!on_in) begin
                     on_in = 1'b1;
                  end else begin
                     rep_in = 1'b0;
                  end
               end
            end
         end else begin
            rec_in.pend_off  = 1'b0;
            rec_in.pend_info = 1'b0;
            if (enable_ff) begin
               if (on_ff) begin
                  if (minute_up) begin
                     start_in = req_chan.now_ms;
                     if (min_inc == MINUTES_PER_HR) begin
                        min_in = '0;
                        hr_in  = hr_ff + 8'd1;
                     end else begin
                        min_in = min_inc;
                     end
                  end
               end else begin
                  start_in = req_chan.now_ms;
                  min_in   = '0;
                  hr_in    = '0;
               end
               pin_in = on_ff ^ invert_ff;
               rec_in.pend_off  = (lim_h_ff != 8'd0 || lim_m_ff != 8'd0)
                                  && hr_in == lim_h_ff && {2'b00, min_in} == lim_m_ff;
               rec_in.pend_info = rep_ff != on_ff;
               rep_in = on_ff;
            end
            rec_in.channel = chan_ff;
            rec_in.zone    = zone_ff;
            rec_in.subzone = subzone_ff;
            rec_in.pin     = pin_in;
            rec_in.on      = on_ff;
            rec_in.hours   = hr_in;
            rec_in.minutes = min_in;
            out_valid_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         invert_ff    <= 1'b0;
         zone_ff      <= '0;
         subzone_ff   <= '0;
         lim_h_ff     <= '0;
         lim_m_ff     <= '0;
         chan_ff      <= '0;
         on_ff        <= 1'b0;
         rep_ff       <= 1'b0;
         start_ff     <= '0;
         min_ff       <= '0;
         hr_ff        <= '0;
         pin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         rec_ff       <= '0;
      end else begin
         on_ff        <= on_in;
         rep_ff       <= rep_in;
         start_ff     <= start_in;
         min_ff       <= min_in;
         hr_ff        <= hr_in;
         pin_ff       <= pin_in;
         out_valid_ff <= out_valid_in;
         rec_ff       <= rec_in;
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               IDX_ENABLE:         enable_ff  <= csr_chan.data[0];
               IDX_INVERT:         invert_ff  <= csr_chan.data[0];
               IDX_ZONE:           zone_ff    <= csr_chan.data;
               IDX_SUBZONE:        subzone_ff <= csr_chan.data;
               IDX_LIMIT_HOURS:    lim_h_ff   <= csr_chan.data;
               IDX_LIMIT_MINUTES:  lim_m_ff   <= csr_chan.data;
               IDX_CHANNEL_NUMBER: chan_ff    <= csr_chan.data;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      if (rec_ff.pend_off) begin
         rsp_chan.kind = KIND_TURN_OFF;
      end else if (rec_ff.pend_info) begin
         rsp_chan.kind = rec_ff.on ? KIND_INFO_ON : KIND_INFO_OFF;
      end else begin
         rsp_chan.kind = KIND_STATUS;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.channel         = rec_ff.channel;
   assign rsp_chan.out_zone        = rec_ff.zone;
   assign rsp_chan.out_subzone     = rec_ff.subzone;
   assign rsp_chan.pin_level       = rec_ff.pin;
   assign rsp_chan.on_state        = rec_ff.on;
   assign rsp_chan.elapsed_hours   = rec_ff.hours;
   assign rsp_chan.elapsed_minutes = rec_ff.minutes;
   assign rsp_chan.last            = out_last;

endmodule

`default_nettype wire

>>> dv/zoc_result_checker.sv
// Result checker for the zoned output channel: watches the request, response and register
// channels, predicts every response transaction and compares it field by field.
// Depends on zoc_pkg and the channel interfaces in zoc_intf.sv.
module zoc_result_checker
   import zoc_pkg::*;
(
   input  wire  clock,
   input  wire  reset,
   zoc_req_if   req,
   zoc_rsp_if   rsp,
   zoc_csr_if   csr,
   output int   fail_count,
   output int   pending_count
);

   localparam int SHOW_LIMIT = 10;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] channel;
      logic [7:0] zone;
      logic [7:0] subzone;
      logic       pin;
      logic       on;
      logic [7:0] hours;
      logic [5:0] minutes;
      logic       last;
   } chan_result_type;

   logic        cfg_enable;
   logic        cfg_invert;
   logic [7:0]  cfg_zone;
   logic [7:0]  cfg_subzone;
   logic [7:0]  cfg_limit_hours;
   logic [7:0]  cfg_limit_minutes;
   logic [7:0]  cfg_channel;

   logic        on_flag;
   logic        reported_flag;
   logic        pin_level;
   logic [15:0] minute_start;
   logic [5:0]  on_minutes;
   logic [7:0]  on_hours;

   chan_result_type expected_results[$];
   int              shown;

   function automatic chan_result_type snapshot(kind_type kind, logic last);
      chan_result_type r;
      r.kind    = kind;
      r.channel = cfg_channel;
      r.zone    = cfg_zone;
      r.subzone = cfg_subzone;
      r.pin     = pin_level;
      r.on      = on_flag;
      r.hours   = on_hours;
      r.minutes = on_minutes;
      r.last    = last;
      return r;
   endfunction

   function automatic void show_result(string tag, chan_result_type r);
      $display("tb:   %s kind=%0d ch=%0d zone=%0d sub=%0d pin=%0d on=%0d hr=%0d min=%0d last=%0d",
               tag, r.kind, r.channel, r.zone, r.subzone, r.pin, r.on, r.hours, r.minutes,
               r.last);
   endfunction

   function automatic void write_register(logic [7:0] index, logic [7:0] data);
      case (index)
         IDX_ENABLE:         cfg_enable        = data[0];
         IDX_INVERT:         cfg_invert        = data[0];
         IDX_ZONE:           cfg_zone          = data;
         IDX_SUBZONE:        cfg_subzone       = data;
         IDX_LIMIT_HOURS:    cfg_limit_hours   = data;
         IDX_LIMIT_MINUTES:  cfg_limit_minutes = data;
         IDX_CHANNEL_NUMBER: cfg_channel       = data;
         default: ;
      endcase
   endfunction

   function automatic void apply_event(logic [15:0] cls, logic [7:0] typ, logic [3:0] size,
                                       logic [7:0] ez, logic [7:0] es);
      if (cfg_enable && cls == CONTROL_CLASS && size == CONTROL_SIZE && ez == cfg_zone &&
          (es == cfg_subzone || es == SUBZONE_ALL)) begin
         if (typ == TURN_OFF_TYPE) begin
            if (on_flag) on_flag = 1'b0;
            else reported_flag = 1'b1;
         end
         if (typ == TURN_ON_TYPE) begin
            if (!on_flag) on_flag = 1'b1;
            else reported_flag = 1'b0;
         end
      end
   endfunction

   function automatic void apply_tick(logic [15:0] now);
      logic [15:0] elapsed;
      if (cfg_enable) begin
         if (on_flag) begin
            elapsed = now - minute_start;
            if (elapsed > MINUTE_MS) begin
               if (on_minutes == MINUTES_PER_HR - 6'd1) begin
                  on_minutes = 6'd0;
                  on_hours   = on_hours + 8'd1;
               end else begin
                  on_minutes = on_minutes + 6'd1;
               end
               minute_start = now;
            end
         end else begin
            minute_start = now;
            on_hours     = 8'd0;
            on_minutes   = 6'd0;
         end
         pin_level = on_flag ^ cfg_invert;
         if ((cfg_limit_hours != 8'd0 || cfg_limit_minutes != 8'd0) &&
             on_hours == cfg_limit_hours && on_minutes == cfg_limit_minutes)
            expected_results.push_back(snapshot(KIND_TURN_OFF, 1'b0));
         if (reported_flag != on_flag)
            expected_results.push_back(snapshot(on_flag ? KIND_INFO_ON : KIND_INFO_OFF, 1'b0));
         reported_flag = on_flag;
      end
      expected_results.push_back(snapshot(KIND_STATUS, 1'b1));
   endfunction

   always @(posedge clock) begin
      chan_result_type got;
      chan_result_type want;
      if (reset) begin
         cfg_enable        = 1'b0;
         cfg_invert        = 1'b0;
         cfg_zone          = 8'd0;
         cfg_subzone       = 8'd0;
         cfg_limit_hours   = 8'd0;
         cfg_limit_minutes = 8'd0;
         cfg_channel       = 8'd0;
         on_flag           = 1'b0;
         reported_flag     = 1'b0;
         pin_level         = 1'b0;
         minute_start      = 16'd0;
         on_minutes        = 6'd0;
         on_hours          = 8'd0;
         expected_results.delete();
         fail_count        = 0;
         shown             = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.kind    = rsp.kind;
            got.channel = rsp.channel;
            got.zone    = rsp.out_zone;
            got.subzone = rsp.out_subzone;
            got.pin     = rsp.pin_level;
            got.on      = rsp.on_state;
            got.hours   = rsp.elapsed_hours;
            got.minutes = rsp.elapsed_minutes;
            got.last    = rsp.last;
            if (expected_results.size() == 0) begin
               fail_count++;
               if (shown < SHOW_LIMIT) begin
                  shown++;
                  $display("tb: response transaction with nothing expected");
                  show_result("actual", got);
               end
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (shown < SHOW_LIMIT) begin
                     shown++;
                     $display("tb: response transaction mismatch");
                     show_result("expected", want);
                     show_result("actual", got);
                  end
               end
            end
         end
         if (csr.valid && csr.ready)
            write_register(csr.index, csr.data);
         if (req.valid && req.ready) begin
            if (req.func == FUNC_TICK)
               apply_tick(req.now_ms);
            else
               apply_event(req.event_class, req.event_type, req.event_size, req.event_zone,
                           req.event_subzone);
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

>>> dv/tb.sv
// Testbench top for the zoned output channel with on-time timer: drives request and
// register transactions, stalls the response side, and reports the checker's verdict.
// Depends on zoc_pkg, zoc_intf.sv, the block under test and zoc_result_checker.
module tb;
   import zoc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;

   zoc_req_if req_if ();
   zoc_rsp_if rsp_if ();
   zoc_csr_if csr_if ();

   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   bit          gapless = 1'b0;
   bit          rsp_hold = 1'b0;
   logic [15:0] now_ms = 16'd0;
   logic [7:0]  cur_zone = 8'd0;
   logic [7:0]  cur_subzone = 8'd0;

   zoned_output_channel_with_timer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   zoc_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .csr           (csr_if),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            gap = HOLD_CYCLES;
         end else begin
            gap = gapless ? 0 : $urandom_range(0, 8);
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic send(func_type f, logic [15:0] now, logic [15:0] cls, logic [7:0] typ,
                       logic [3:0] size, logic [7:0] ez, logic [7:0] es);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.func          <= f;
      req_if.now_ms        <= now;
      req_if.event_class   <= cls;
      req_if.event_type    <= typ;
      req_if.event_size    <= size;
      req_if.event_zone    <= ez;
      req_if.event_subzone <= es;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic tick_at(logic [15:0] t);
      now_ms = t;
      send(FUNC_TICK, t, 16'($urandom), 8'($urandom), 4'($urandom_range(0, 8)),
           8'($urandom), 8'($urandom));
   endtask

   task automatic control(logic [7:0] typ, logic [7:0] sub);
      send(FUNC_EVENT, 16'($urandom), CONTROL_CLASS, typ, CONTROL_SIZE, cur_zone, sub);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] index, logic [7:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic set_config(logic en, logic inv, logic [7:0] zone, logic [7:0] sub,
                             logic [7:0] lim_h, logic [7:0] lim_m, logic [7:0] chan);
      wait_idle();
      write_reg(IDX_ENABLE, {7'($urandom), en});
      write_reg(IDX_INVERT, {7'($urandom), inv});
      write_reg(IDX_ZONE, zone);
      write_reg(IDX_SUBZONE, sub);
      write_reg(IDX_LIMIT_HOURS, lim_h);
      write_reg(IDX_LIMIT_MINUTES, lim_m);
      write_reg(IDX_CHANNEL_NUMBER, chan);
      write_reg(8'($urandom_range(IDX_CHANNEL_NUMBER + 1, 255)), 8'($urandom));
      csr_if.valid <= 1'b0;
      cur_zone    = zone;
      cur_subzone = sub;
   endtask

   task automatic random_tick(int big_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < big_pct)
         tick_at(now_ms + 16'($urandom_range(60001, 65535)));
      else if (r < big_pct + 3)
         tick_at(now_ms + MINUTE_MS);
      else if (r < big_pct + 6)
         tick_at(16'($urandom));
      else
         tick_at(now_ms + 16'($urandom_range(0, 59999)));
   endtask

   task automatic random_event(int on_pct);
      logic [15:0] cls;
      logic [7:0]  typ;
      logic [3:0]  size;
      logic [7:0]  ez;
      logic [7:0]  es;
      cls  = CONTROL_CLASS;
      typ  = ($urandom_range(0, 99) < on_pct) ? TURN_ON_TYPE : TURN_OFF_TYPE;
      size = CONTROL_SIZE;
      ez   = cur_zone;
      es   = ($urandom_range(0, 3) == 0) ? SUBZONE_ALL : cur_subzone;
      case ($urandom_range(0, 17))
         0: cls = 16'($urandom);
         1: size = 4'($urandom_range(0, 8));
         2: ez = 8'($urandom);
         3: es = 8'($urandom);
         4: typ = 8'($urandom);
         5: begin
            cls  = 16'($urandom);
            typ  = 8'($urandom);
            size = 4'($urandom_range(0, 8));
            ez   = 8'($urandom);
            es   = 8'($urandom);
         end
         default: ;
      endcase
      send(FUNC_EVENT, 16'($urandom), cls, typ, size, ez, es);
   endtask

   task automatic run_random(int count, int tick_pct, int big_pct, int on_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < tick_pct) random_tick(big_pct);
         else random_event(on_pct);
      end
   endtask

   initial begin
      req_if.valid         <= 1'b0;
      req_if.func          <= FUNC_EVENT;
      req_if.now_ms        <= 16'd0;
      req_if.event_class   <= 16'd0;
      req_if.event_type    <= 8'd0;
      req_if.event_size    <= 4'd0;
      req_if.event_zone    <= 8'd0;
      req_if.event_subzone <= 8'd0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= 8'd0;
      csr_if.data          <= 8'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // The channel comes out of reset disabled: events are ignored, ticks give status only.
      wait_idle();
      tick_at(16'd0);
      control(TURN_ON_TYPE, SUBZONE_ALL);
      send(FUNC_EVENT, 16'hFFFF, 16'hFFFF, 8'hFF, 4'd8, 8'hFF, 8'hFF);
      tick_at(16'hFFFF);

      set_config(1'b1, 1'b0, 8'h12, 8'h34, 8'd0, 8'd2, 8'hA5);
      tick_at(16'd100);
      control(TURN_ON_TYPE, cur_subzone);
      tick_at(16'd200);
      tick_at(16'd100 + MINUTE_MS);
      tick_at(16'd101 + MINUTE_MS);
      tick_at(now_ms + 16'hFFFF);
      control(TURN_ON_TYPE, cur_subzone);
      tick_at(now_ms + 16'd10);
      control(TURN_OFF_TYPE, SUBZONE_ALL);
      tick_at(now_ms + 16'd10);
      control(TURN_OFF_TYPE, cur_subzone);
      tick_at(now_ms + 16'd10);
      send(FUNC_EVENT, 16'd0, CONTROL_CLASS ^ 16'h8000, TURN_ON_TYPE, CONTROL_SIZE, cur_zone,
           cur_subzone);
      send(FUNC_EVENT, 16'd0, CONTROL_CLASS, TURN_ON_TYPE, 4'd2, cur_zone, cur_subzone);
      send(FUNC_EVENT, 16'd0, CONTROL_CLASS, TURN_ON_TYPE, CONTROL_SIZE, cur_zone ^ 8'h01,
           cur_subzone);
      send(FUNC_EVENT, 16'd0, CONTROL_CLASS, TURN_ON_TYPE, CONTROL_SIZE, cur_zone,
           cur_subzone ^ 8'h80);
      control(8'd7, cur_subzone);
      tick_at(now_ms + 16'd10);

      rsp_hold = 1'b1;
      run_random(50, 60, 40, 60);

      set_config(1'b1, 1'b1, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'hFF);
      run_random(25, 55, 40, 50);
      wait_idle();
      run_random(25, 55, 40, 50);

      // Long on-time run so that the hour counter reaches its limit.
      set_config(1'b1, 1'b0, 8'h00, 8'h00, 8'd1, 8'd0, 8'h00);
      gapless = 1'b1;
      control(TURN_ON_TYPE, cur_subzone);
      run_random(150, 92, 97, 100);
      gapless = 1'b0;

      set_config(1'b0, 1'b1, 8'h33, 8'h44, 8'd0, 8'd1, 8'h11);
      run_random(30, 50, 40, 60);

      set_config(1'b1, 1'b1, 8'h5A, 8'hC3, 8'hFF, 8'hFF, 8'h3C);
      rsp_hold = 1'b1;
      run_random(50, 60, 50, 70);

      set_config(1'b1, 1'b0, 8'h80, 8'h01, 8'd0, 8'd1, 8'h7E);
      run_random(60, 60, 40, 60);

      set_config(1'b1, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 1)),
                 8'($urandom_range(0, 3)), 8'($urandom));
      run_random(60, 60, 45, 65);

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

>>> files.f
rtl/zoc_pkg.sv
rtl/zoc_intf.sv
rtl/zoned_output_channel_with_timer_top.sv
dv/zoc_result_checker.sv
dv/tb.sv
